/* rtl/bpfa_pkg.sv */
// Shared types and constants for the batch-admit packet FIFO.
// Used by bpfa_store, bpfa_ctrl and bounded_packet_fifo_batch_admit.
package bpfa_pkg;

	localparam int BUF_AW = 14;
	localparam int PKT_AW = 6;
	localparam int BCNT_W = 15;
	localparam int PCNT_W = 7;
	localparam int LEN_W  = 11;

	localparam logic [BCNT_W:0]   BUF_BYTES   = 16'd16384;
	localparam logic [PCNT_W:0]   MAX_PKTS    = 8'd64;
	localparam logic [LEN_W-1:0]  MAX_PKT_LEN = 11'd1316;

	localparam logic [PCNT_W-1:0] PKT_LIMIT_RST  = 7'd64;
	localparam logic [BCNT_W-1:0] BYTE_LIMIT_RST = 15'd16384;

	localparam logic CFG_PKT_LIMIT  = 1'b0;
	localparam logic CFG_BYTE_LIMIT = 1'b1;

	localparam logic [2:0] MODE_PUSH   = 3'd0;
	localparam logic [2:0] MODE_POP    = 3'd1;
	localparam logic [2:0] MODE_CLEAR  = 3'd2;
	localparam logic [2:0] MODE_CANCEL = 3'd3;
	localparam logic [2:0] MODE_RESET  = 3'd4;

	localparam logic [3:0] ST_STAGED     = 4'd0;
	localparam logic [3:0] ST_ACCEPTED   = 4'd1;
	localparam logic [3:0] ST_BAD_PACKET = 4'd2;
	localparam logic [3:0] ST_CANCELLED  = 4'd3;
	localparam logic [3:0] ST_NO_ROOM    = 4'd4;
	localparam logic [3:0] ST_POPPED     = 4'd5;
	localparam logic [3:0] ST_EMPTY      = 4'd6;
	localparam logic [3:0] ST_POP_CANCEL = 4'd7;
	localparam logic [3:0] ST_DONE       = 4'd8;

	typedef struct packed {
		logic [PCNT_W-1:0] packet_limit;
		logic [BCNT_W-1:0] byte_limit;
	} cfg_t;

	typedef struct packed {
		logic              byte_we;
		logic [BUF_AW-1:0] byte_wa;
		logic [7:0]        byte_wd;
		logic              byte_re;
		logic [BUF_AW-1:0] byte_ra;
		logic              len_we;
		logic [PKT_AW-1:0] len_wa;
		logic [LEN_W-1:0]  len_wd;
		logic              len_re;
		logic [PKT_AW-1:0] len_ra;
	} mem_req_t;

	typedef struct packed {
		logic [7:0]       byte_rd;
		logic [LEN_W-1:0] len_rd;
	} mem_rsp_t;

endpackage

/* rtl/bpfa_store.sv */
// Byte ring and packet length ring, one write and one registered read port each.
// Depends on bpfa_pkg.
module bpfa_store
	import bpfa_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output mem_rsp_t rsp
);

	logic [7:0]       byte_mem [2**BUF_AW];
	logic [LEN_W-1:0] len_mem  [2**PKT_AW];
	logic [7:0]       byte_rd_q;
	logic [LEN_W-1:0] len_rd_q;

	always_ff @(posedge clk) begin
		if (req.byte_we) begin
			byte_mem[req.byte_wa] <= req.byte_wd;
		end
		if (req.byte_re) begin
			byte_rd_q <= byte_mem[req.byte_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (req.len_we) begin
			len_mem[req.len_wa] <= req.len_wd;
		end
		if (req.len_re) begin
			len_rd_q <= len_mem[req.len_ra];
		end
	end

	assign rsp.byte_rd = byte_rd_q;
	assign rsp.len_rd  = len_rd_q;

endmodule

/* rtl/bpfa_ctrl.sv */
// Request sequencing, staging, batch admission and pop logic of the packet FIFO.
// Depends on bpfa_pkg; drives the memories in bpfa_store.
module bpfa_ctrl
	import bpfa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        mode,
	input  logic [7:0]        data_byte,
	input  logic              has_data,
	input  logic              packet_end,
	input  logic              batch_end,
	output mem_req_t          mem_req,
	input  mem_rsp_t          mem_rsp,
	output logic              result_valid,
	output logic [3:0]        status,
	output logic [7:0]        out_byte,
	output logic              out_packet_end,
	output logic [BCNT_W-1:0] bytes_stored,
	output logic [PCNT_W-1:0] packets_stored,
	output logic [BCNT_W-1:0] high_water
);

	logic              accept;
	logic              vld_s1;
	logic [2:0]        mode_s1;
	logic [7:0]        data_s1;
	logic              has_data_s1;
	logic              pkt_end_s1;
	logic              batch_end_s1;

	logic [BUF_AW-1:0] rd_ptr_q, wr_ptr_q, stg_ptr_q;
	logic [PKT_AW-1:0] len_head_q, len_tail_q;
	logic [BCNT_W-1:0] byte_cnt_q, peak_q, stg_bytes_q;
	logic [PCNT_W-1:0] pkt_cnt_q, stg_pkts_q;
	logic [LEN_W-1:0]  cur_len_q, pop_off_q;
	logic              cancel_q, stg_bad_q, stg_full_q;

	logic [BUF_AW-1:0] rd_ptr_d, wr_ptr_d, stg_ptr_d;
	logic [PKT_AW-1:0] len_head_d, len_tail_d;
	logic [BCNT_W-1:0] byte_cnt_d, peak_d, stg_bytes_d;
	logic [PCNT_W-1:0] pkt_cnt_d, stg_pkts_d;
	logic [LEN_W-1:0]  cur_len_d, pop_off_d;
	logic              cancel_d, stg_bad_d, stg_full_d;

	logic              res_vld_q, res_end_q, res_end_d;
	logic [3:0]        res_st_q, res_st_d;
	logic [7:0]        res_byte_q, res_byte_d;

	logic [LEN_W-1:0]  len1, po1;
	logic              bad1, full1, close;
	logic [BCNT_W-1:0] sb1, free_b, bc_new;
	logic [PCNT_W-1:0] sp1, free_p, pc_new;
	logic [BUF_AW-1:0] stp1;

	assign accept = start & ~vld_s1;
	assign busy   = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1      <= mode;
			data_s1      <= data_byte;
			has_data_s1  <= has_data;
			pkt_end_s1   <= packet_end;
			batch_end_s1 <= batch_end;
		end
	end

	always_comb begin
		mem_req         = '0;
		mem_req.byte_re = accept;
		mem_req.byte_ra = rd_ptr_q;
		mem_req.len_re  = accept;
		mem_req.len_ra  = len_head_q;

		rd_ptr_d    = rd_ptr_q;
		wr_ptr_d    = wr_ptr_q;
		stg_ptr_d   = stg_ptr_q;
		len_head_d  = len_head_q;
		len_tail_d  = len_tail_q;
		byte_cnt_d  = byte_cnt_q;
		peak_d      = peak_q;
		stg_bytes_d = stg_bytes_q;
		pkt_cnt_d   = pkt_cnt_q;
		stg_pkts_d  = stg_pkts_q;
		cur_len_d   = cur_len_q;
		pop_off_d   = pop_off_q;
		cancel_d    = cancel_q;
		stg_bad_d   = stg_bad_q;
		stg_full_d  = stg_full_q;
		res_st_d    = ST_DONE;
		res_byte_d  = 8'd0;
		res_end_d   = 1'b0;

		len1   = cur_len_q;
		bad1   = stg_bad_q;
		full1  = stg_full_q;
		sb1    = stg_bytes_q;
		sp1    = stg_pkts_q;
		stp1   = stg_ptr_q;
		close  = 1'b0;
		po1    = pop_off_q + 11'd1;
		free_p = cfg.packet_limit - ((pkt_cnt_q < cfg.packet_limit) ? pkt_cnt_q
			: cfg.packet_limit);
		free_b = cfg.byte_limit - ((byte_cnt_q < cfg.byte_limit) ? byte_cnt_q
			: cfg.byte_limit);
		bc_new = byte_cnt_q;
		pc_new = pkt_cnt_q;

		if (vld_s1) begin
			unique case (mode_s1)
				MODE_PUSH: begin
					if (has_data_s1) begin
						if (cur_len_q >= MAX_PKT_LEN) begin
							bad1 = 1'b1;
						end else begin
							len1 = cur_len_q + 11'd1;
							if (({1'b0, byte_cnt_q} + {1'b0, stg_bytes_q}) < BUF_BYTES) begin
								mem_req.byte_we = 1'b1;
								mem_req.byte_wa = stg_ptr_q;
								mem_req.byte_wd = data_s1;
								stp1 = stg_ptr_q + 14'd1;
								sb1  = stg_bytes_q + 15'd1;
							end else begin
								full1 = 1'b1;
							end
						end
					end
					close = pkt_end_s1 | (batch_end_s1 & (len1 != '0));
					if (close) begin
						if (len1 == '0) begin
							bad1 = 1'b1;
						end else if (({1'b0, pkt_cnt_q} + {1'b0, stg_pkts_q}) < MAX_PKTS) begin
							mem_req.len_we = 1'b1;
							mem_req.len_wa = len_tail_q + stg_pkts_q[PKT_AW-1:0];
							mem_req.len_wd = len1;
							sp1 = stg_pkts_q + 7'd1;
						end else begin
							full1 = 1'b1;
						end
						len1 = '0;
					end
					if (batch_end_s1) begin
						priority if (bad1) begin
							res_st_d = ST_BAD_PACKET;
						end else if (cancel_q) begin
							res_st_d = ST_CANCELLED;
						end else if (full1 || sp1 > free_p || sb1 > free_b) begin
							res_st_d = ST_NO_ROOM;
						end else begin
							res_st_d = ST_ACCEPTED;
						end
						if (res_st_d == ST_ACCEPTED) begin
							bc_new     = byte_cnt_q + sb1;
							pc_new     = pkt_cnt_q + sp1;
							wr_ptr_d   = stp1;
							len_tail_d = len_tail_q + sp1[PKT_AW-1:0];
							byte_cnt_d = bc_new;
							pkt_cnt_d  = pc_new;
							if (bc_new > peak_q) begin
								peak_d = bc_new;
							end
						end
						stg_ptr_d   = (res_st_d == ST_ACCEPTED) ? stp1 : wr_ptr_q;
						stg_bytes_d = '0;
						stg_pkts_d  = '0;
						cur_len_d   = '0;
						stg_bad_d   = 1'b0;
						stg_full_d  = 1'b0;
					end else begin
						res_st_d    = ST_STAGED;
						stg_ptr_d   = stp1;
						stg_bytes_d = sb1;
						stg_pkts_d  = sp1;
						cur_len_d   = len1;
						stg_bad_d   = bad1;
						stg_full_d  = full1;
					end
				end
				MODE_POP: begin
					priority if (cancel_q) begin
						res_st_d = ST_POP_CANCEL;
					end else if (pkt_cnt_q == '0) begin
						res_st_d = ST_EMPTY;
					end else begin
						res_st_d   = ST_POPPED;
						res_byte_d = mem_rsp.byte_rd;
						rd_ptr_d   = rd_ptr_q + 14'd1;
						pop_off_d  = po1;
						if (po1 >= mem_rsp.len_rd) begin
							res_end_d  = 1'b1;
							pop_off_d  = '0;
							len_head_d = len_head_q + 6'd1;
							pkt_cnt_d  = pkt_cnt_q - 7'd1;
							byte_cnt_d = (byte_cnt_q > {4'd0, mem_rsp.len_rd})
								? byte_cnt_q - {4'd0, mem_rsp.len_rd} : '0;
						end
					end
				end
				MODE_CLEAR, MODE_CANCEL, MODE_RESET: begin
					rd_ptr_d    = '0;
					wr_ptr_d    = '0;
					stg_ptr_d   = '0;
					len_head_d  = '0;
					len_tail_d  = '0;
					byte_cnt_d  = '0;
					pkt_cnt_d   = '0;
					stg_bytes_d = '0;
					stg_pkts_d  = '0;
					cur_len_d   = '0;
					stg_bad_d   = 1'b0;
					stg_full_d  = 1'b0;
					pop_off_d   = '0;
					if (mode_s1 == MODE_CANCEL) begin
						cancel_d = 1'b1;
					end
					if (mode_s1 == MODE_RESET) begin
						cancel_d = 1'b0;
						peak_d   = '0;
					end
				end
				default: begin
					res_st_d = ST_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			stg_ptr_q   <= '0;
			len_head_q  <= '0;
			len_tail_q  <= '0;
			byte_cnt_q  <= '0;
			peak_q      <= '0;
			stg_bytes_q <= '0;
			pkt_cnt_q   <= '0;
			stg_pkts_q  <= '0;
			cur_len_q   <= '0;
			pop_off_q   <= '0;
			cancel_q    <= 1'b0;
			stg_bad_q   <= 1'b0;
			stg_full_q  <= 1'b0;
			res_vld_q   <= 1'b0;
		end else begin
			rd_ptr_q    <= rd_ptr_d;
			wr_ptr_q    <= wr_ptr_d;
			stg_ptr_q   <= stg_ptr_d;
			len_head_q  <= len_head_d;
			len_tail_q  <= len_tail_d;
			byte_cnt_q  <= byte_cnt_d;
			peak_q      <= peak_d;
			stg_bytes_q <= stg_bytes_d;
			pkt_cnt_q   <= pkt_cnt_d;
			stg_pkts_q  <= stg_pkts_d;
			cur_len_q   <= cur_len_d;
			pop_off_q   <= pop_off_d;
			cancel_q    <= cancel_d;
			stg_bad_q   <= stg_bad_d;
			stg_full_q  <= stg_full_d;
			res_vld_q   <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			res_st_q   <= res_st_d;
			res_byte_q <= res_byte_d;
			res_end_q  <= res_end_d;
		end
	end

	assign result_valid   = res_vld_q;
	assign status         = res_st_q;
	assign out_byte       = res_byte_q;
	assign out_packet_end = res_end_q;
	assign bytes_stored   = byte_cnt_q;
	assign packets_stored = pkt_cnt_q;
	assign high_water     = peak_q;

endmodule

/* rtl/bounded_packet_fifo_batch_admit.sv */
// Top level of the batch-admit packet FIFO: limit registers, control and memories.
// Depends on bpfa_pkg, bpfa_store and bpfa_ctrl.
// A taken request is held in the request stage (vld_s1), then in the result registers
// that drive the result strobe. busy is high for the cycle after each request, so no
// new request is taken while the registered reads of the byte and length rings complete.
// Reset: arst_n clears pointers, counts, staging, cancel and high water at once and
// loads the limits to 64 packets and 16384 bytes; memory contents stay as they are.
// Results cannot be stalled: each is presented for exactly one cycle.
module bounded_packet_fifo_batch_admit
	import bpfa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        mode,
	input  logic [7:0]        data_byte,
	input  logic              has_data,
	input  logic              packet_end,
	input  logic              batch_end,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [BCNT_W-1:0] cfg_data,
	output logic              result_valid,
	output logic [3:0]        status,
	output logic [7:0]        out_byte,
	output logic              out_packet_end,
	output logic [BCNT_W-1:0] bytes_stored,
	output logic [PCNT_W-1:0] packets_stored,
	output logic [BCNT_W-1:0] high_water
);

	cfg_t     cfg_q;
	mem_req_t mem_req;
	mem_rsp_t mem_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.packet_limit <= PKT_LIMIT_RST;
			cfg_q.byte_limit   <= BYTE_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PKT_LIMIT:  cfg_q.packet_limit <= cfg_data[PCNT_W-1:0];
				CFG_BYTE_LIMIT: cfg_q.byte_limit   <= cfg_data;
				default:        cfg_q              <= cfg_q;
			endcase
		end
	end

	bpfa_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.data_byte      (data_byte),
		.has_data       (has_data),
		.packet_end     (packet_end),
		.batch_end      (batch_end),
		.mem_req        (mem_req),
		.mem_rsp        (mem_rsp),
		.result_valid   (result_valid),
		.status         (status),
		.out_byte       (out_byte),
		.out_packet_end (out_packet_end),
		.bytes_stored   (bytes_stored),
		.packets_stored (packets_stored),
		.high_water     (high_water)
	);

	bpfa_store u_store (
		.clk (clk),
		.req (mem_req),
		.rsp (mem_rsp)
	);

endmodule
